// File: hdl/pbi_pkg.sv
// Package with constants and types for the projectile bounce integrator.
package pbi_pkg;
  localparam int WordW = 32;
  localparam int DtW = 16;
  localparam int FricW = 24;
  localparam logic signed [WordW-1:0] AccelYReset = -32'sd642253;
  localparam logic [FricW-1:0] FricReset = 24'd168;
  localparam logic signed [WordW-1:0] VelYReset = 32'sd2621440;
  localparam logic [1:0] RegAccelX = 2'd0;
  localparam logic [1:0] RegAccelY = 2'd1;
  localparam logic [1:0] RegAccelZ = 2'd2;
  localparam logic [1:0] RegFric = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_VEL, ST_POS, ST_SQ, ST_SQRT, ST_DIV, ST_APPLY, ST_FLOOR, ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
  } ctl_t;

  function automatic logic signed [WordW-1:0] sat32(input logic signed [WordW+1:0] x);
    if (x > $signed({3'b000, {(WordW-1){1'b1}}})) return {1'b0, {(WordW-1){1'b1}}};
    if (x < $signed({3'b111, {(WordW-1){1'b0}}})) return {1'b1, {(WordW-1){1'b0}}};
    return x[WordW-1:0];
  endfunction
endpackage

// File: hdl/projectile_bounce_integrator.sv
// Top level of the projectile bounce integrator.
// A step runs from the step beat to the result beat through velocity, position, the squares,
// the square root, three friction divisions (one per lane) and the floor check; at zero speed
// the divisions are skipped.
// The next step waits for the result.
// Reset (synchronous, rst high): position zero, velocity (0, 40.0, 0), accel (0, -9.8, 0).
module projectile_bounce_integrator import pbi_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,   // step_time
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [191:0] m_axis_tdata,   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
  output logic         m_axis_tuser,   // bounced
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  state_t state, state_next;
  logic signed [WordW-1:0] acc [3];
  logic [FricW-1:0] fric;
  logic signed [WordW-1:0] pos [3];
  logic signed [WordW-1:0] vel [3];
  logic [DtW-1:0] dt;
  logic [1:0] lane;
  logic [5:0] bitc;
  logic [63:0] macc;      // serial product / square accumulator
  logic [63:0] sumsq;
  logic [63:0] sq_n;
  logic [63:0] sq_res;
  logic [63:0] sq_bit;
  logic [31:0] mag;
  logic [55:0] fprod;
  logic bounce;
  logic div_done;
  logic [63:0] quo;
  ctl_t dctl;
  logic start_next;
  logic signed [WordW-1:0] mul_op;
  logic signed [WordW-1:0] mul_base;
  logic signed [63:0] prod_s;
  logic signed [63:0] rnd;
  logic [31:0] absv;
  logic signed [WordW+1:0] sum_wide;
  logic signed [WordW+1:0] fric_wide;

  assign cfg_ready = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata = {vel[2], vel[1], vel[0], pos[2], pos[1], pos[0]};
  assign m_axis_tuser = bounce;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (s_axis_tvalid) state_next = ST_VEL;
      ST_VEL:   if (bitc == 6'd15 && lane == 2'd2) state_next = ST_POS;
      ST_POS:   if (bitc == 6'd15 && lane == 2'd2) state_next = ST_SQ;
      ST_SQ:    if (bitc == 6'd31 && lane == 2'd2) state_next = ST_SQRT;
      ST_SQRT:  if (sq_bit == '0) state_next = (sq_res == '0) ? ST_FLOOR : ST_DIV;
      ST_DIV:   if (div_done) state_next = ST_APPLY;
      ST_APPLY: state_next = (lane == 2'd2) ? ST_FLOOR : ST_DIV;
      ST_FLOOR: state_next = ST_OUT;
      ST_OUT:   if (m_axis_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    absv = vel[lane][31] ? 32'(-vel[lane]) : vel[lane];
    mul_op = (state == ST_VEL) ? acc[lane] : vel[lane];
    mul_base = (state == ST_VEL) ? vel[lane] : pos[lane];
    // The top dt bit is folded into the final sum instead of the accumulator.
    prod_s = dt[15] ? $signed(macc) + (64'(mul_op) <<< 15) : $signed(macc);
    rnd = (prod_s + 64'sd32768) >>> 16;
    sum_wide = 34'(mul_base) + 34'(rnd);
    fric_wide = vel[lane][31] ? 34'(vel[lane]) + $signed(34'(quo))
                              : 34'(vel[lane]) - $signed(34'(quo));
    start_next = (state == ST_SQRT && sq_bit == '0 && sq_res != '0) ||
                 (state == ST_APPLY && lane != 2'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc[0] <= '0; acc[1] <= AccelYReset; acc[2] <= '0;
      fric <= FricReset;
      pos[0] <= '0; pos[1] <= '0; pos[2] <= '0;
      vel[0] <= '0; vel[1] <= VelYReset; vel[2] <= '0;
      lane <= '0; bitc <= '0; bounce <= 1'b0;
      dctl.start <= 1'b0;
    end else begin
      dctl.start <= start_next;
      if (cfg_valid) begin
        case (cfg_index)
          RegAccelX: acc[0] <= cfg_data;
          RegAccelY: acc[1] <= cfg_data;
          RegAccelZ: acc[2] <= cfg_data;
          RegFric:   fric <= cfg_data[FricW-1:0];
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: if (s_axis_tvalid) begin
          dt <= s_axis_tdata;
          lane <= '0; bitc <= '0; macc <= '0; bounce <= 1'b0;
        end
        ST_VEL, ST_POS: begin
          if (bitc == 6'd15) begin
            if (state == ST_VEL) vel[lane] <= sat32(sum_wide);
            else pos[lane] <= sat32(sum_wide);
            macc <= '0; bitc <= '0;
            lane <= (lane == 2'd2) ? 2'd0 : lane + 2'd1;
            if (lane == 2'd2) sumsq <= '0;
          end else begin
            // signed operand times one dt bit per cycle
            if (dt[bitc[3:0]]) macc <= macc + (64'(mul_op) <<< bitc);
            bitc <= bitc + 6'd1;
          end
        end
        ST_SQ: begin
          if (bitc == 6'd31) begin
            sumsq <= sumsq + (absv[31] ? macc + ({32'd0, absv} << 31) : macc);
            macc <= '0; bitc <= '0;
            lane <= (lane == 2'd2) ? 2'd0 : lane + 2'd1;
            if (lane == 2'd2) begin
              sq_n <= sumsq + (absv[31] ? macc + ({32'd0, absv} << 31) : macc);
              sq_res <= '0;
              sq_bit <= 64'd1 << 62;
            end
          end else begin
            if (absv[bitc[4:0]]) macc <= macc + ({32'd0, absv} << bitc);
            bitc <= bitc + 6'd1;
          end
        end
        ST_SQRT: begin
          if (sq_bit != '0) begin
            if (sq_n >= sq_res + sq_bit) begin
              sq_n <= sq_n - (sq_res + sq_bit);
              sq_res <= (sq_res >> 1) + sq_bit;
            end else sq_res <= sq_res >> 1;
            sq_bit <= sq_bit >> 2;
          end else begin
            mag <= sq_res[31:0];
            lane <= '0;
            fprod <= 56'(absv) * 56'(fric);
          end
        end
        ST_DIV: ;
        ST_APPLY: begin
          vel[lane] <= sat32(fric_wide);
          if (lane != 2'd2) begin
            fprod <= 56'($unsigned(vel[lane+2'd1][31] ? 32'(-vel[lane+2'd1])
                                                      : vel[lane+2'd1])) * 56'(fric);
          end
          lane <= (lane == 2'd2) ? 2'd0 : lane + 2'd1;
        end
        ST_FLOOR: begin
          lane <= '0;
          if (pos[1][31]) begin
            pos[1] <= '0;
            vel[1] <= sat32(-$signed({{2{vel[1][31]}}, vel[1]}));
            bounce <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  pbi_serial_div u_div (
    .clk(clk), .rst(rst), .ctl(dctl),
    .num(64'(fprod) + {25'd0, mag, 7'd0}),
    .den({mag, 8'd0}),
    .done(div_done), .quo(quo)
  );
endmodule

// File: hdl/pbi_serial_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module pbi_serial_div import pbi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  ctl_t        ctl,
  input  logic [63:0] num,
  input  logic [39:0] den,
  output logic        done,
  output logic [63:0] quo
);
  logic [40:0] rem;
  logic [63:0] q;
  logic [6:0]  cnt;
  logic        run;
  logic [40:0] trial;

  always_comb trial = {rem[39:0], q[63]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= !ctl.start && run && (cnt == 7'd63);
      if (ctl.start) begin
        run <= 1'b1;
        cnt <= '0;
        rem <= '0;
        q <= num;
      end else if (run) begin
        if (!trial[40]) begin
          rem <= trial;
          q <= {q[62:0], 1'b1};
        end else begin
          rem <= {rem[39:0], q[63]};
          q <= {q[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) run <= 1'b0;
      end
    end
  end
  assign quo = q;
endmodule

// File: hdl/pbi_checker.sv
// Port-level checker for the projectile bounce integrator, bound to the top level.
module pbi_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [191:0] m_axis_tdata,
  input logic         m_axis_tuser
);
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid)) else $error("accept while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_floor: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !m_axis_tdata[63]) else $error("pos_y negative");
  a_bounce: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[63:32] == 32'd0)
    else $error("bounce without clamp");
endmodule

bind projectile_bounce_integrator pbi_checker u_chk (.*);
